FILE: rtl/bpaq_pkg.sv
package bpaq_pkg;

  localparam int POOL_SLOTS  = 32;
  localparam int QUEUE_DEPTH = 32;

  localparam int SLOT_W = 5;
  localparam int IDX_W  = $clog2(POOL_SLOTS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_ENQUEUE = 2'd2,
    REQ_DEQUEUE = 2'd3
  } req_type_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic push;
  } ctl_cmd_t;

endpackage

FILE: rtl/bpaq_req_if.sv
interface bpaq_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [bpaq_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output req_type, output slot, input ready);
  modport sink (input valid, input req_type, input slot, output ready);
endinterface

FILE: rtl/bpaq_rsp_if.sv
interface bpaq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      success;
  logic [bpaq_pkg::SLOT_W-1:0] slot_out;

  modport source (output valid, output success, output slot_out, input ready);
  modport sink (input valid, input success, input slot_out, output ready);
endinterface

FILE: rtl/bpaq_ctrl.sv
module bpaq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output bpaq_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = req_valid_i;
        if (req_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

FILE: rtl/bpaq_datapath.sv
module bpaq_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpaq_pkg::ctl_cmd_t          cmd_i,
  input  logic [1:0]                  req_type_i,
  input  logic [bpaq_pkg::SLOT_W-1:0] slot_i,
  output logic                        success_o,
  output logic [bpaq_pkg::SLOT_W-1:0] slot_out_o
);

  localparam int PoolSlots  = bpaq_pkg::POOL_SLOTS;
  localparam int QueueDepth = bpaq_pkg::QUEUE_DEPTH;
  localparam int IdxW       = bpaq_pkg::IDX_W;
  localparam int PtrW       = bpaq_pkg::PTR_W;
  localparam int SlotW      = bpaq_pkg::SLOT_W;

  logic [PoolSlots-1:0] busy_q, busy_d;
  logic [IdxW-1:0]      start_q, start_d;
  logic [PtrW-1:0]      head_q, head_d;
  logic [PtrW-1:0]      tail_q, tail_d;

  bpaq_pkg::req_type_e  req_q;
  logic [SlotW-1:0]     slot_q;
  logic                 res_success_q, res_success_d;
  logic [SlotW-1:0]     res_slot_q, res_slot_d;
  logic                 res_deq_q, res_deq_d;
  logic [SlotW-1:0]     rd_q;
  logic                 out_success_q;
  logic [SlotW-1:0]     out_slot_q;

  logic [SlotW-1:0]     queue_mem [QueueDepth];

  logic [PoolSlots-1:0] free_v;
  logic                 hi_found, lo_found;
  logic [IdxW-1:0]      hi_pos, lo_pos, grant_pos;
  logic                 grant_ok;
  logic [PtrW-1:0]      head_nxt, tail_nxt;
  logic                 q_full, q_empty, slot_valid;
  logic                 do_enq, do_deq;

  assign free_v = ~busy_q;

  always_comb begin
    hi_found = 1'b0;
    hi_pos   = '0;
    lo_found = 1'b0;
    lo_pos   = '0;
    for (int i = PoolSlots - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        lo_found = 1'b1;
        lo_pos   = IdxW'(i);
        if (i >= int'(start_q)) begin
          hi_found = 1'b1;
          hi_pos   = IdxW'(i);
        end
      end
    end
  end

  assign grant_ok  = hi_found || lo_found;
  assign grant_pos = hi_found ? hi_pos : lo_pos;

  assign head_nxt   = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt   = (tail_q == PtrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
  assign q_full     = (tail_nxt == head_q);
  assign q_empty    = (head_q == tail_q);
  assign slot_valid = (int'(slot_q) < PoolSlots);
  assign do_enq     = cmd_i.exec && (req_q == bpaq_pkg::REQ_ENQUEUE) && !q_full;
  assign do_deq     = cmd_i.exec && (req_q == bpaq_pkg::REQ_DEQUEUE) && !q_empty;

  always_comb begin
    busy_d        = busy_q;
    start_d       = start_q;
    head_d        = head_q;
    tail_d        = tail_q;
    res_success_d = 1'b0;
    res_slot_d    = '0;
    res_deq_d     = 1'b0;
    unique case (req_q)
      bpaq_pkg::REQ_ALLOC: begin
        if (grant_ok) begin
          busy_d[grant_pos] = 1'b1;
          start_d = (grant_pos == IdxW'(PoolSlots - 1)) ? '0 : grant_pos + 1'b1;
          res_success_d = 1'b1;
          res_slot_d    = SlotW'(grant_pos);
        end else begin
          start_d = '0;
        end
      end
      bpaq_pkg::REQ_RELEASE: begin
        if (slot_valid) begin
          busy_d[IdxW'(slot_q)] = 1'b0;
          res_success_d = 1'b1;
        end
      end
      bpaq_pkg::REQ_ENQUEUE: begin
        if (!q_full) begin
          tail_d        = tail_nxt;
          res_success_d = 1'b1;
        end
      end
      bpaq_pkg::REQ_DEQUEUE: begin
        if (!q_empty) begin
          head_d        = head_nxt;
          res_success_d = 1'b1;
          res_deq_d     = 1'b1;
        end
      end
      default: begin
        res_success_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      start_q <= IdxW'(1);
      head_q  <= '0;
      tail_q  <= '0;
    end else if (cmd_i.exec) begin
      busy_q  <= busy_d;
      start_q <= start_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= bpaq_pkg::req_type_e'(req_type_i);
      slot_q <= slot_i;
    end
    if (cmd_i.exec) begin
      res_success_q <= res_success_d;
      res_slot_q    <= res_slot_d;
      res_deq_q     <= res_deq_d;
    end
    if (cmd_i.push) begin
      out_success_q <= res_success_q;
      out_slot_q    <= res_deq_q ? rd_q : res_slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      queue_mem[tail_q] <= slot_q;
    end
    if (do_deq) begin
      rd_q <= queue_mem[head_q];
    end
  end

  assign success_o  = out_success_q;
  assign slot_out_o = out_slot_q;

endmodule

FILE: rtl/buffer_pool_alloc_queue.sv
// Channel   Direction  Handshake        Payload
// req_i     in         valid / ready    req_type (2), slot (5)
// rsp_o     out        valid / ready    success (1), slot_out (5)
//
// Each item is handled in order: accept, execute, and load of the result register.
// The execute cycle holds the next-fit search over the busy bitmap and the queue update;
// a dequeue reads the queue memory there and the registered data is used when the result register is loaded.
// A new item is accepted while the previous result still waits in the result register.
// A stalled result holds the block in its final step until the register frees up.
// Reset is asynchronous and needs no clearing pass.
module buffer_pool_alloc_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpaq_req_if.sink   req_i,
  bpaq_rsp_if.source rsp_o
);

  bpaq_pkg::ctl_cmd_t cmd;

  bpaq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  bpaq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_type_i (req_i.req_type),
    .slot_i     (req_i.slot),
    .success_o  (rsp_o.success),
    .slot_out_o (rsp_o.slot_out)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SLOT_W      = bpaq_pkg::SLOT_W;
  localparam int POOL_SLOTS  = bpaq_pkg::POOL_SLOTS;
  localparam int QUEUE_DEPTH = bpaq_pkg::QUEUE_DEPTH;

  localparam int ITEMS_PER_PHASE = 180;
  localparam int LONG_HOLD       = 300;
  localparam int TAIL_CYCLES     = 16;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic                success;
    logic [SLOT_W-1:0]   slot_out;
  } outcome_t;

  typedef struct packed {
    bpaq_pkg::req_type_e op;
    logic [SLOT_W-1:0]   slot;
    logic [5:0]          rep;
    logic                typed;
    logic                success;
    logic [SLOT_W-1:0]   slot_out;
  } directed_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bpaq_req_if req_if ();
  bpaq_rsp_if rsp_if ();

  buffer_pool_alloc_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk = ~clk;

  logic [POOL_SLOTS-1:0] pool_busy;
  int                    search_from;
  logic [SLOT_W-1:0]     slot_ring [QUEUE_DEPTH];
  int                    ring_head;
  int                    ring_tail;

  outcome_t pending_outcomes [$];
  int       errors        = 0;
  int       send_idle_pct = 0;
  int       rsp_stall_pct = 0;
  int       holds_asked   = 0;
  int       holds_granted = 0;
  int       cycle_count   = 0;

  int idle_pct_by_phase  [4] = '{0, 49, 0, 26};
  int stall_pct_by_phase [4] = '{0, 0, 49, 26};

  // Rows with typed set carry a result that follows directly from the state.
  directed_row_t directed_rows [23] = '{
    '{bpaq_pkg::REQ_DEQUEUE, 5'd0,  6'd1,  1'b1, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd1,  1'b1, 1'b1, 5'd1},
    '{bpaq_pkg::REQ_ALLOC,   5'd31, 6'd1,  1'b1, 1'b1, 5'd2},
    '{bpaq_pkg::REQ_RELEASE, 5'd31, 6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_RELEASE, 5'd1,  6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd1,  1'b0, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_ENQUEUE, 5'd0,  6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_ENQUEUE, 5'd31, 6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_DEQUEUE, 5'd17, 6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_DEQUEUE, 5'd0,  6'd1,  1'b1, 1'b1, 5'd31},
    '{bpaq_pkg::REQ_DEQUEUE, 5'd0,  6'd1,  1'b1, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd40, 1'b0, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd1,  1'b1, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_RELEASE, 5'd0,  6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_RELEASE, 5'd31, 6'd1,  1'b1, 1'b1, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd1,  1'b1, 1'b1, 5'd31},
    '{bpaq_pkg::REQ_ENQUEUE, 5'd0,  6'd31, 1'b0, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_ENQUEUE, 5'd31, 6'd1,  1'b1, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_DEQUEUE, 5'd0,  6'd31, 1'b0, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_DEQUEUE, 5'd0,  6'd1,  1'b1, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_RELEASE, 5'd0,  6'd32, 1'b0, 1'b0, 5'd0},
    '{bpaq_pkg::REQ_ALLOC,   5'd0,  6'd1,  1'b0, 1'b0, 5'd0}
  };

  function automatic outcome_t serve_request(bpaq_pkg::req_type_e op,
                                             logic [SLOT_W-1:0] s);
    outcome_t r;
    int       pos;
    bit       found;
    r     = '0;
    found = 1'b0;
    case (op)
      bpaq_pkg::REQ_ALLOC: begin
        for (int k = 0; k < POOL_SLOTS; k++) begin
          pos = (search_from + k) % POOL_SLOTS;
          if (!found && !pool_busy[pos]) begin
            found          = 1'b1;
            pool_busy[pos] = 1'b1;
            search_from    = (pos + 1) % POOL_SLOTS;
            r.success      = 1'b1;
            r.slot_out     = SLOT_W'(pos);
          end
        end
        if (!found) begin
          search_from = 0;
        end
      end
      bpaq_pkg::REQ_RELEASE: begin
        if (int'(s) < POOL_SLOTS) begin
          pool_busy[s] = 1'b0;
          r.success    = 1'b1;
        end
      end
      bpaq_pkg::REQ_ENQUEUE: begin
        if ((ring_tail + 1) % QUEUE_DEPTH != ring_head) begin
          slot_ring[ring_tail] = s;
          ring_tail            = (ring_tail + 1) % QUEUE_DEPTH;
          r.success            = 1'b1;
        end
      end
      default: begin
        if (ring_head != ring_tail) begin
          r.slot_out = slot_ring[ring_head];
          ring_head  = (ring_head + 1) % QUEUE_DEPTH;
          r.success  = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(0, 1) ? SLOT_W'(POOL_SLOTS - 1) : '0;
    end
    return SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
  endfunction

  function automatic logic [SLOT_W-1:0] pick_busy_slot();
    int start;
    int pos;
    start = $urandom_range(0, POOL_SLOTS - 1);
    for (int k = 0; k < POOL_SLOTS; k++) begin
      pos = (start + k) % POOL_SLOTS;
      if (pool_busy[pos]) begin
        return SLOT_W'(pos);
      end
    end
    return SLOT_W'(start);
  endfunction

  task automatic send_item(bpaq_pkg::req_type_e op, logic [SLOT_W-1:0] s, bit typed,
                           outcome_t typed_val);
    outcome_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.slot     <= s;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
    predicted = serve_request(op, s);
    pending_outcomes.push_back(typed ? typed_val : predicted);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_burst(output int sent);
    int                  mode;
    int                  len;
    bpaq_pkg::req_type_e op;
    logic [SLOT_W-1:0]   s;
    mode = $urandom_range(0, 5);
    len  = $urandom_range(4, 36);
    for (int i = 0; i < len; i++) begin
      s = pick_slot();
      case (mode)
        2: op = ($urandom_range(0, 99) < 85) ? bpaq_pkg::REQ_ALLOC : bpaq_pkg::REQ_RELEASE;
        3: begin
          op = bpaq_pkg::REQ_RELEASE;
          if ($urandom_range(0, 99) < 80) begin
            s = pick_busy_slot();
          end
        end
        4: op = ($urandom_range(0, 9) == 0) ? bpaq_pkg::REQ_DEQUEUE : bpaq_pkg::REQ_ENQUEUE;
        5: op = ($urandom_range(0, 9) == 0) ? bpaq_pkg::REQ_ENQUEUE : bpaq_pkg::REQ_DEQUEUE;
        default: op = bpaq_pkg::req_type_e'($urandom_range(0, 3));
      endcase
      send_item(op, s, 1'b0, '0);
    end
    sent = len;
  endtask

  initial begin : req_side
    int       phase_items;
    int       sent;
    bit       held;
    outcome_t typed_val;
    pool_busy    = '0;
    search_from  = 1 % POOL_SLOTS;
    ring_head    = 0;
    ring_tail    = 0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= bpaq_pkg::REQ_ALLOC;
    req_if.slot     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      typed_val = '{success: directed_rows[r].success, slot_out: directed_rows[r].slot_out};
      for (int i = 0; i < int'(directed_rows[r].rep); i++) begin
        send_item(directed_rows[r].op, directed_rows[r].slot + SLOT_W'(i),
                  directed_rows[r].typed, typed_val);
      end
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_pct_by_phase[ph];
      rsp_stall_pct = stall_pct_by_phase[ph];
      phase_items   = 0;
      held          = 1'b0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if (!held && phase_items >= ITEMS_PER_PHASE / 3) begin
          held = 1'b1;
          holds_asked++;
        end
        run_burst(sent);
        phase_items += sent;
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", pending_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : rsp_side
    outcome_t want;
    int       stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with no item outstanding: success %0b slot_out %0d",
                 rsp_if.success, rsp_if.slot_out);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_if.success !== want.success) begin
            $error("success: expected %0b, actual %0b", want.success, rsp_if.success);
            errors++;
          end
          if (rsp_if.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, rsp_if.slot_out);
            errors++;
          end
        end
      end
      if (holds_granted != holds_asked) begin
        holds_granted++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
